/* sv/assert_macros.svh */
// Assertion macros shared by the voice allocator RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AVSA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AVSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/avsa_pkg.sv */
// Package for the voice-stealing allocator: sizes, codes and payload types.
// No dependencies.
`default_nettype none

package avsa_pkg;

  localparam int NUM_VOICES = 32;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W      = $clog2(NUM_VOICES + 1);

  localparam int ACT_W   = 6;
  localparam int CMP_W   = ACT_W + 1;
  localparam int ENT_W   = 10;
  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 24;
  localparam int VOICE_W = 5;

  localparam int PADDR_W = 3;
  localparam int DATA_W  = 32;

  localparam logic [TIME_W-1:0] LIFE_START = 32'h7fff_ffff;
  localparam logic [ACT_W-1:0]  ACTIVE_RST = 6'd32;
  localparam logic [ENT_W-1:0]  PLAYER_RST = 10'd1;

  typedef enum logic {
    REG_ACTIVE = 1'b0,
    REG_PLAYER = 1'b1
  } reg_idx_t;

  typedef enum logic {
    KIND_PICK  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ENT_W-1:0]    entity;
    logic [SLOT_W-1:0]   sub_channel;
    logic [TIME_W-1:0]   now;
    logic [LEN_W-1:0]    sound_length;
  } in_req_t;

  typedef struct packed {
    logic                granted;
    logic [VOICE_W-1:0]  voice;
    logic                same_source;
  } out_res_t;

  typedef struct packed {
    logic [ENT_W-1:0]    owner;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   end_time;
    logic                busy;
  } voice_ent_t;

  typedef struct packed {
    logic                init;
    logic                en;
    logic [VIDX_W-1:0]   idx;
  } scan_ctl_t;

  typedef struct packed {
    logic                hit;
    logic                found;
    logic                same_source;
    logic [VIDX_W-1:0]   pick;
  } scan_stat_t;

endpackage

`default_nettype wire

/* sv/audio_voice_steal_allocator_top.sv */
// Voice-stealing allocator top: request sequencer, config registers,
// voice table and compare unit. Uses avsa_pkg, avsa_voice_ram, avsa_scan.
//
// Usage:
//   A request is taken when start is high and busy is low. kind selects a
//   pick (choose and rewrite a voice) or a clear of the whole voice table.
//   Each request gives exactly one result on out_res, shown for one cycle
//   with out_valid high; the receiver cannot stall it.
//   A pick reads one voice per cycle from the voice table through the
//   single compare unit, over N = min(active_voices, NUM_VOICES) voices
//   (fewer when a same-source voice ends the scan early), then writes the
//   chosen voice and shows the result; busy is high meanwhile.
//   An active count of zero skips the scan. A clear empties the whole
//   voice table at once. A new request may be taken in the cycle in
//   which the previous result is shown.
//   Config registers sit on the APB-style port: active_voices at 0x0,
//   player_entity at 0x4; pready is always high. Write them only while
//   busy is low and no result is pending.
//   Reset empties the voice table, sets active_voices to 32 and
//   player_entity to 1, and leaves the block idle.
`default_nettype none
`include "assert_macros.svh"

module audio_voice_steal_allocator_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  avsa_pkg::in_req_t                 in_req,
  output logic                              out_valid,
  output avsa_pkg::out_res_t                out_res,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [avsa_pkg::PADDR_W-1:0]      paddr,
  input  wire  [avsa_pkg::DATA_W-1:0]       pwdata,
  output logic [avsa_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  avsa_pkg::in_req_t               req_r, req_nxt;
  logic [avsa_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic                            chk_vld_r;
  logic [avsa_pkg::VIDX_W-1:0]     chk_idx_r;
  logic [avsa_pkg::ACT_W-1:0]      active_r;
  logic [avsa_pkg::ENT_W-1:0]      player_r;
  logic                            out_valid_r, out_valid_nxt;
  avsa_pkg::out_res_t              out_res_r, out_res_nxt;

  logic                            accept;
  logic                            issue;
  logic                            clear_all;
  logic                            wr_en;
  logic                            scan_init;
  logic                            cfg_wr;
  logic [avsa_pkg::CNT_W-1:0]      count_w;
  avsa_pkg::reg_idx_t              reg_idx;
  avsa_pkg::voice_ent_t            rd_data;
  avsa_pkg::voice_ent_t            wr_data;
  avsa_pkg::scan_ctl_t             scan_ctl;
  avsa_pkg::scan_stat_t            scan_stat;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = avsa_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= avsa_pkg::ACTIVE_RST;
      player_r <= avsa_pkg::PLAYER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        avsa_pkg::REG_ACTIVE: active_r <= pwdata[avsa_pkg::ACT_W-1:0];
        avsa_pkg::REG_PLAYER: player_r <= pwdata[avsa_pkg::ENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      avsa_pkg::REG_ACTIVE: prdata = avsa_pkg::DATA_W'(active_r);
      avsa_pkg::REG_PLAYER: prdata = avsa_pkg::DATA_W'(player_r);
      default:              prdata = '0;
    endcase
  end

  // scanned voice count, clamped to the table size
  always_comb begin
    if (avsa_pkg::CMP_W'(active_r) > avsa_pkg::CMP_W'(avsa_pkg::NUM_VOICES)) begin
      count_w = avsa_pkg::CNT_W'(avsa_pkg::NUM_VOICES);
    end else begin
      count_w = avsa_pkg::CNT_W'(active_r);
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (state_r == S_SCAN) && (idx_r != count_w);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    clear_all     = 1'b0;
    wr_en         = 1'b0;
    scan_init     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req;
          idx_nxt   = '0;
          scan_init = 1'b1;
          if (in_req.kind == avsa_pkg::KIND_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (count_w == '0) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + avsa_pkg::CNT_W'(1);
        end
        if (scan_stat.hit || !issue) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        wr_en                   = scan_stat.found;
        out_valid_nxt           = 1'b1;
        out_res_nxt.granted     = scan_stat.found;
        out_res_nxt.voice       = scan_stat.found ?
                                  avsa_pkg::VOICE_W'(scan_stat.pick) : '0;
        out_res_nxt.same_source = scan_stat.same_source;
        state_nxt               = S_IDLE;
      end
      S_CLEAR: begin
        clear_all     = 1'b1;
        out_valid_nxt = 1'b1;
        out_res_nxt   = '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
    chk_idx_r <= idx_r[avsa_pkg::VIDX_W-1:0];
  end

  assign wr_data.owner    = req_r.entity;
  assign wr_data.slot     = req_r.sub_channel;
  assign wr_data.end_time = req_r.now + avsa_pkg::TIME_W'(req_r.sound_length);
  assign wr_data.busy     = 1'b1;

  avsa_voice_ram u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (clear_all),
    .rd_en     (issue),
    .rd_addr   (idx_r[avsa_pkg::VIDX_W-1:0]),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (scan_stat.pick),
    .wr_data   (wr_data)
  );

  assign scan_ctl.init = scan_init;
  assign scan_ctl.en   = (state_r == S_SCAN) && chk_vld_r;
  assign scan_ctl.idx  = chk_idx_r;

  avsa_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (scan_ctl),
    .req    (req_r),
    .player (player_r),
    .ent    (rd_data),
    .stat   (scan_stat)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `AVSA_ASSERT_IMPLIES(a_out_after_end, out_valid_r, ($past(state_r) == S_WRITE) || ($past(state_r) == S_CLEAR), "result strobe without a finishing state")
  `AVSA_ASSERT_NEXT(a_hit_ends_scan, (state_r == S_SCAN) && scan_stat.hit, (state_r == S_WRITE) && scan_stat.same_source, "same source hit did not end the scan")
  `AVSA_ASSERT_IMPLIES(a_scan_bound, state_r == S_SCAN, idx_r <= count_w, "scan index past the active count")

endmodule

`default_nettype wire

/* sv/avsa_voice_ram.sv */
// Voice table: one-write, one-read memory with registered read data and
// per-entry valid bits (invalid entries read as zero). Uses avsa_pkg.
`default_nettype none

module avsa_voice_ram (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             clear_all,
  input  wire                             rd_en,
  input  wire  [avsa_pkg::VIDX_W-1:0]     rd_addr,
  output avsa_pkg::voice_ent_t            rd_data,
  input  wire                             wr_en,
  input  wire  [avsa_pkg::VIDX_W-1:0]     wr_addr,
  input  avsa_pkg::voice_ent_t            wr_data
);

  avsa_pkg::voice_ent_t                  mem [avsa_pkg::NUM_VOICES];
  logic [avsa_pkg::NUM_VOICES-1:0]       vld_r;
  avsa_pkg::voice_ent_t                  rdq_r;
  logic                                  rdv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (clear_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rdv_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdq_r <= mem[rd_addr];
    end
  end

  assign rd_data = rdv_r ? rdq_r : '0;

endmodule

`default_nettype wire

/* sv/avsa_scan.sv */
// Shared compare unit: one voice per enabled cycle, same-source match,
// player protection and signed remaining-time minimum. Uses avsa_pkg.
`default_nettype none
`include "assert_macros.svh"

module avsa_scan (
  input  wire                             clk,
  input  wire                             rst_n,
  input  avsa_pkg::scan_ctl_t             ctl,
  input  avsa_pkg::in_req_t               req,
  input  wire  [avsa_pkg::ENT_W-1:0]      player,
  input  avsa_pkg::voice_ent_t            ent,
  output avsa_pkg::scan_stat_t            stat
);

  logic [avsa_pkg::TIME_W-1:0]  best_r;
  logic [avsa_pkg::VIDX_W-1:0]  pick_r;
  logic                         found_r;
  logic                         same_r;

  logic                         same_hit;
  logic                         protect;
  logic [avsa_pkg::TIME_W-1:0]  rem;
  logic                         better;

  assign same_hit = (req.sub_channel != '0) && (ent.owner == req.entity) &&
                    (ent.slot == req.sub_channel);
  assign protect  = (ent.owner == player) && (req.entity != player) && ent.busy;
  assign rem      = ent.end_time - req.now;
  assign better   = $signed(rem) < $signed(best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      same_r  <= 1'b0;
    end else if (ctl.init) begin
      found_r <= 1'b0;
      same_r  <= 1'b0;
    end else if (ctl.en) begin
      if (same_hit) begin
        found_r <= 1'b1;
        same_r  <= 1'b1;
      end else if (!protect && better) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      best_r <= avsa_pkg::LIFE_START;
      pick_r <= '0;
    end else if (ctl.en) begin
      if (same_hit) begin
        pick_r <= ctl.idx;
      end else if (!protect && better) begin
        best_r <= rem;
        pick_r <= ctl.idx;
      end
    end
  end

  assign stat.hit         = ctl.en && same_hit;
  assign stat.found       = found_r;
  assign stat.same_source = same_r;
  assign stat.pick        = pick_r;

  `AVSA_ASSERT_IMPLIES(a_same_has_found, same_r, found_r, "same source without a pick")

endmodule

`default_nettype wire

/* test/audio_voice_steal_allocator_top_tb.sv */
// Testbench for audio_voice_steal_allocator_top: directed and random pick/clear
// requests, predicted in-bench and checked result by result. Uses avsa_pkg.
`default_nettype none

module audio_voice_steal_allocator_top_tb;
  import avsa_pkg::*;

  localparam int TIMEOUT = 12 * 600000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_req_t             in_req;
  logic                out_valid;
  out_res_t            out_res;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  audio_voice_steal_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predicted voice table and register copies
  logic [ENT_W-1:0]   tbl_owner [NUM_VOICES];
  logic [SLOT_W-1:0]  tbl_slot  [NUM_VOICES];
  logic [TIME_W-1:0]  tbl_end   [NUM_VOICES];
  logic               tbl_busy  [NUM_VOICES];
  logic [ACT_W-1:0]   cfg_active;
  logic [ENT_W-1:0]   cfg_player;

  in_req_t            req_q [$];
  out_res_t           grant_q [$];
  int unsigned        pushed_cnt;
  int unsigned        taken_cnt;
  int unsigned        clear_cnt;
  int unsigned        checked_cnt;
  int unsigned        cfg_writes;
  int unsigned        err_cnt;
  int unsigned        gap_pct;
  logic               taken;
  logic [TIME_W-1:0]  t_now;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void clear_table();
    for (int i = 0; i < NUM_VOICES; i++) begin
      tbl_owner[i] = '0;
      tbl_slot[i]  = '0;
      tbl_end[i]   = '0;
      tbl_busy[i]  = 1'b0;
    end
  endfunction

  function automatic out_res_t pick_voice(in_req_t r);
    out_res_t          res;
    int unsigned       cnt;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] rem;
    int                pick;
    bit                hit;
    bit                found;
    res = '0;
    if (r.kind == KIND_CLEAR) begin
      clear_table();
      return res;
    end
    cnt   = (cfg_active > NUM_VOICES) ? NUM_VOICES : cfg_active;
    best  = LIFE_START;
    pick  = 0;
    hit   = 1'b0;
    found = 1'b0;
    for (int i = 0; i < cnt; i++) begin
      if (!hit) begin
        if (r.sub_channel != 0 && tbl_owner[i] == r.entity && tbl_slot[i] == r.sub_channel) begin
          pick  = i;
          hit   = 1'b1;
          found = 1'b1;
        end else if (!(tbl_owner[i] == cfg_player && r.entity != cfg_player && tbl_busy[i])) begin
          rem = tbl_end[i] - r.now;
          if ($signed(rem) < $signed(best)) begin
            best  = rem;
            pick  = i;
            found = 1'b1;
          end
        end
      end
    end
    if (found) begin
      tbl_owner[pick] = r.entity;
      tbl_slot[pick]  = r.sub_channel;
      tbl_busy[pick]  = 1'b1;
      tbl_end[pick]   = r.now + TIME_W'(r.sound_length);
      res.granted     = 1'b1;
      res.voice       = pick[VOICE_W-1:0];
      res.same_source = hit;
    end
    return res;
  endfunction

  // driver: next request presented at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (req_q.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        in_req <= req_q.pop_front();
        start  <= 1'b1;
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // monitor: results checked before a same-edge request is predicted
  always @(posedge clk) begin
    taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        checked_cnt++;
        if (grant_q.size() == 0) begin
          if (err_cnt < 10)
            $display("ERROR: unexpected result granted=%0b voice=%0d same=%0b",
                     out_res.granted, out_res.voice, out_res.same_source);
          err_cnt++;
        end else begin
          out_res_t want;
          want = grant_q.pop_front();
          if (out_res.granted !== want.granted || out_res.voice !== want.voice ||
              out_res.same_source !== want.same_source) begin
            if (err_cnt < 10)
              $display("ERROR: result %0d expected granted=%0b voice=%0d same=%0b, got %0b %0d %0b",
                       checked_cnt, want.granted, want.voice, want.same_source,
                       out_res.granted, out_res.voice, out_res.same_source);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        if (in_req.kind == KIND_CLEAR) clear_cnt++;
        grant_q.push_back(pick_voice(in_req));
        taken_cnt++;
      end
    end
  end

  task automatic wait_drain();
    @(negedge clk);
    while (taken_cnt != pushed_cnt || grant_q.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_ACTIVE) cfg_active = val[ACT_W-1:0];
    else cfg_player = val[ENT_W-1:0];
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(int unsigned act, int unsigned player, int unsigned gap);
    wait_drain();
    reg_write(REG_ACTIVE, DATA_W'(act));
    reg_write(REG_PLAYER, DATA_W'(player));
    gap_pct = gap;
  endtask

  task automatic push_req(kind_t k, int unsigned ent, int unsigned sub,
                          logic [TIME_W-1:0] now, int unsigned len);
    in_req_t r;
    r.kind         = k;
    r.entity       = ENT_W'(ent);
    r.sub_channel  = SLOT_W'(sub);
    r.now          = now;
    r.sound_length = LEN_W'(len);
    req_q.push_back(r);
    pushed_cnt++;
  endtask

  // mostly advancing time and a small pool of entities so that slots get reused
  task automatic push_random(int unsigned n);
    in_req_t     r;
    int unsigned sel;
    repeat (n) begin
      r.kind = ($urandom_range(0, 99) < 3) ? KIND_CLEAR : KIND_PICK;
      sel = $urandom_range(0, 9);
      if (sel < 3) r.entity = cfg_player;
      else if (sel < 7) r.entity = ENT_W'($urandom_range(0, 7));
      else r.entity = ENT_W'($urandom_range(0, 1023));
      r.sub_channel = SLOT_W'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 85) begin
        t_now = t_now + TIME_W'($urandom_range(0, 3000));
        r.now = t_now;
      end else begin
        r.now = $urandom;
      end
      if ($urandom_range(0, 99) < 60) r.sound_length = LEN_W'($urandom_range(0, 20000));
      else r.sound_length = LEN_W'($urandom);
      req_q.push_back(r);
      pushed_cnt++;
    end
  endtask

  task automatic run_phase(int unsigned act, int unsigned player, int unsigned gap,
                           int unsigned n);
    set_regs(act, player, gap);
    push_random(n / 2);
    wait_drain();
    push_random(n - n / 2);
    wait_drain();
  endtask

  initial begin
    #TIMEOUT;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    taken       = 1'b0;
    gap_pct     = 0;
    pushed_cnt  = 0;
    taken_cnt   = 0;
    clear_cnt   = 0;
    checked_cnt = 0;
    cfg_writes  = 0;
    err_cnt     = 0;
    t_now       = '0;
    cfg_active  = ACTIVE_RST;
    cfg_player  = PLAYER_RST;
    clear_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full table, player 1: ties, wrap, same-source, player protection, clear
    set_regs(32, 1, 0);
    push_req(KIND_PICK, 0, 0, 32'h0, 0);
    push_req(KIND_PICK, 1023, 7, 32'hffff_ffff, 24'hff_ffff);
    push_req(KIND_PICK, 1, 1, 32'h0, 100);
    push_req(KIND_PICK, 5, 2, 32'd10, 50);
    push_req(KIND_PICK, 5, 2, 32'd20, 50);
    push_req(KIND_PICK, 5, 0, 32'd25, 50);
    push_req(KIND_PICK, 2, 1, 32'd30, 40);
    push_req(KIND_PICK, 1, 1, 32'd30, 40);
    push_req(KIND_CLEAR, 1023, 7, 32'hffff_ffff, 24'hff_ffff);
    push_req(KIND_PICK, 0, 0, 32'd0, 1);

    // one voice: remaining time at the signed maximum, protected voice
    set_regs(1, 1023, 0);
    push_req(KIND_CLEAR, 0, 0, 32'h0, 0);
    push_req(KIND_PICK, 3, 0, 32'h8000_0001, 5);
    push_req(KIND_PICK, 1023, 4, 32'h0, 0);
    push_req(KIND_PICK, 3, 4, 32'h0, 0);
    push_req(KIND_PICK, 1023, 4, 32'h0, 9);

    // no voice scanned
    set_regs(0, 1023, 0);
    push_req(KIND_PICK, 7, 3, 32'h1234_5678, 77);
    push_req(KIND_PICK, 1023, 0, 32'h0, 0);
    push_req(KIND_CLEAR, 0, 0, 32'h0, 0);

    // count above the table size, player entity 0
    set_regs(63, 0, 0);
    push_req(KIND_PICK, 0, 3, 32'h0, 7);
    push_req(KIND_PICK, 0, 3, 32'h0, 7);
    push_req(KIND_PICK, 9, 3, 32'h0, 7);
    push_req(KIND_PICK, 9, 6, 32'h4000_0000, 24'h80_0000);
    push_req(KIND_PICK, 512, 5, 32'h7fff_ffff, 3);

    run_phase(32, 1, 0, 300);
    run_phase(63, $urandom_range(0, 1023), 81, 200);
    run_phase(1, 0, 6, 150);
    run_phase($urandom_range(1, 32), $urandom_range(0, 1023), 0, 250);
    run_phase(0, 1023, 81, 40);
    run_phase(32, 1023, 6, 300);
    run_phase($urandom_range(0, 63), $urandom_range(0, 1023), 81, 150);
    run_phase(4, 1, 0, 140);

    wait_drain();
    repeat (NUM_VOICES + 8) @(negedge clk);
    if (grant_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", grant_q.size());
      err_cnt += grant_q.size();
    end

    $display("Summary: %0d requests (%0d clears), %0d results checked, %0d register writes",
             taken_cnt, clear_cnt, checked_cnt, cfg_writes);
    $display("Summary: active counts 0, 1, 32, 63 and random; sender gaps 0, 6, 81 percent");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* audio_voice_steal_allocator_top.f */
+incdir+sv
sv/avsa_pkg.sv
sv/avsa_voice_ram.sv
sv/avsa_scan.sv
sv/audio_voice_steal_allocator_top.sv
test/audio_voice_steal_allocator_top_tb.sv
